/* rtl/core/rgb_def_pkg.sv */
// Package for the RGB 3x3 diagonal edge filter.
// Holds the payload structs, the queue entry type and fixed constants.
// No dependencies; every other file in rtl/core imports it.
package rgb_def_pkg;

  localparam int unsigned ChW      = 8;
  localparam int unsigned PxW      = 3 * ChW;
  localparam int unsigned PosW     = 12;
  localparam int unsigned DimW     = 13;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  // Largest row or column count the position counters can cover.
  localparam int unsigned CountLimit = 4096;
  localparam logic [DimW-1:0] MinDim = 13'd3;
  localparam logic [DimW-1:0] CountCap = 13'd4096;

  localparam logic [DimW-1:0] WidthReset  = 13'd640;
  localparam logic [DimW-1:0] HeightReset = 13'd480;

  // Register indexes, taken from paddr bit 2.
  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = 3;

  typedef struct packed {
    logic            start_of_frame;
    logic [ChW-1:0]  in_red;
    logic [ChW-1:0]  in_green;
    logic [ChW-1:0]  in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [PosW-1:0] out_row;
    logic [PosW-1:0] out_col;
    logic [ChW-1:0]  out_red;
    logic [ChW-1:0]  out_green;
    logic [ChW-1:0]  out_blue;
    logic            is_edge_value;
    logic            last_of_run;
  } pix_out_t;

  // One classified pixel on its way from the front to the back part.
  typedef struct packed {
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic            has_inner;
    logic            has_border;
    logic [PxW-1:0]  px;
    logic [PxW-1:0]  top_left;
    logic [PxW-1:0]  top_right;
    logic [PxW-1:0]  bot_left;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

/* rtl/core/rgb_def_regs.sv */
// Configuration registers of the edge filter behind an APB-style port.
// Depends on rgb_def_pkg.
module rgb_def_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rgb_def_pkg::CfgAddrW-1:0]   paddr,
  input  logic [rgb_def_pkg::CfgDataW-1:0]   pwdata,
  output logic [rgb_def_pkg::CfgDataW-1:0]   prdata,
  output logic                               pready,
  output logic [rgb_def_pkg::DimW-1:0]       image_width_o,
  output logic [rgb_def_pkg::DimW-1:0]       image_height_o
);
  import rgb_def_pkg::*;

  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  logic            wr_en;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (reg_sel)
        RegImageWidth:  width_d  = pwdata[DimW-1:0];
        RegImageHeight: height_d = pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegImageWidth:  prdata = {{(CfgDataW-DimW){1'b0}}, width_q};
      RegImageHeight: prdata = {{(CfgDataW-DimW){1'b0}}, height_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign image_width_o  = width_q;
  assign image_height_o = height_q;

endmodule

/* rtl/core/rgb_def_front.sv */
// Front part of the edge filter: raster position, line stores and window.
// Classifies each pixel and hands the window taps to the queue.
// Depends on rgb_def_pkg.
module rgb_def_front #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rgb_def_pkg::pix_in_t          in_data_i,
  input  logic [rgb_def_pkg::DimW-1:0]  image_width_i,
  input  logic [rgb_def_pkg::DimW-1:0]  image_height_i,
  input  rgb_def_pkg::queue_stat_t      queue_stat_i,
  output logic                          push_o,
  output rgb_def_pkg::job_t             job_o
);
  import rgb_def_pkg::*;

  localparam int unsigned Depth = (MAX_WIDTH < CountLimit) ? MAX_WIDTH : CountLimit;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [DimW-1:0] WidthCap = DimW'(Depth);

  logic [PxW-1:0] upper_mem  [Depth];
  logic [PxW-1:0] middle_mem [Depth];

  logic [DimW-1:0] eff_w, eff_h;
  logic [DimW-1:0] c0, r0, c1, r1, r2, c_next, r_next;
  logic [PosW-1:0] cur_row, cur_col;
  logic            cur_inner, cur_border;
  logic            in_fire;

  logic [PosW-1:0] row_q, row_d, col_q, col_d;

  logic            s1_valid_q;
  logic [PosW-1:0] s1_row_q, s1_col_q;
  logic [PxW-1:0]  s1_px_q;
  logic            s1_inner_q, s1_border_q;
  logic [PxW-1:0]  up_rd_q, mid_rd_q;
  logic            hit_q;
  logic [PxW-1:0]  fwd_up_q, fwd_mid_q;
  logic [PxW-1:0]  up_s1, mid_s1;
  logic            s1_go, hit_d;

  logic [PxW-1:0]  win0_top_q, win0_bot_q, win1_top_q, win1_bot_q;

  always_comb begin
    eff_w = image_width_i;
    if (eff_w < MinDim) eff_w = MinDim;
    if (eff_w > WidthCap) eff_w = WidthCap;
    eff_h = image_height_i;
    if (eff_h < MinDim) eff_h = MinDim;
    if (eff_h > CountCap) eff_h = CountCap;
  end

  // Position of the incoming pixel, folding a start of frame and any wrap
  // left over from a smaller image size.
  always_comb begin
    c0 = in_data_i.start_of_frame ? '0 : {1'b0, col_q};
    r0 = in_data_i.start_of_frame ? '0 : {1'b0, row_q};
    if (c0 >= eff_w) begin
      c1 = '0;
      r1 = r0 + 13'd1;
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= eff_h) ? '0 : r1;
    cur_row = r2[PosW-1:0];
    cur_col = c1[PosW-1:0];

    cur_inner  = (cur_row >= 12'd2) && (cur_col >= 12'd2);
    cur_border = (cur_row == 12'd0) || (r2 == eff_h - 13'd1) ||
                 (cur_col == 12'd0) || (c1 == eff_w - 13'd1);

    c_next = c1 + 13'd1;
    r_next = r2 + 13'd1;
    if (c_next >= eff_w) begin
      col_d = '0;
      row_d = (r_next >= eff_h) ? '0 : r_next[PosW-1:0];
    end else begin
      col_d = c_next[PosW-1:0];
      row_d = cur_row;
    end
  end

  // Stage 1 retires every pixel; it needs a queue slot only if it yields results.
  assign s1_go      = s1_valid_q && (!(s1_inner_q || s1_border_q) || !queue_stat_i.full);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_fire    = in_valid_i && in_ready_o;

  // A read at the same edge as a write to the same column sees the old entry,
  // so the written values are forwarded.
  assign hit_d  = s1_go && (s1_col_q == cur_col);
  assign up_s1  = hit_q ? fwd_up_q  : up_rd_q;
  assign mid_s1 = hit_q ? fwd_mid_q : mid_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      up_rd_q  <= upper_mem[cur_col[AddrW-1:0]];
      mid_rd_q <= middle_mem[cur_col[AddrW-1:0]];
    end
    if (s1_go) begin
      upper_mem[s1_col_q[AddrW-1:0]]  <= mid_s1;
      middle_mem[s1_col_q[AddrW-1:0]] <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_row_q    <= cur_row;
      s1_col_q    <= cur_col;
      s1_px_q     <= {in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue};
      s1_inner_q  <= cur_inner;
      s1_border_q <= cur_border;
      fwd_up_q    <= mid_s1;
      fwd_mid_q   <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
      hit_q      <= 1'b0;
      win0_top_q <= '0;
      win0_bot_q <= '0;
      win1_top_q <= '0;
      win1_bot_q <= '0;
    end else begin
      if (in_fire) begin
        row_q <= row_d;
        col_q <= col_d;
        hit_q <= hit_d;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        win1_top_q <= win0_top_q;
        win1_bot_q <= win0_bot_q;
        win0_top_q <= up_s1;
        win0_bot_q <= s1_px_q;
      end
    end
  end

  assign push_o = s1_go && (s1_inner_q || s1_border_q);

  always_comb begin
    job_o.row        = s1_row_q;
    job_o.col        = s1_col_q;
    job_o.has_inner  = s1_inner_q;
    job_o.has_border = s1_border_q;
    job_o.px         = s1_px_q;
    job_o.top_left   = win1_top_q;
    job_o.top_right  = up_s1;
    job_o.bot_left   = win1_bot_q;
  end

endmodule

/* rtl/core/rgb_def_queue.sv */
// Short queue of classified pixels between the front and back parts.
// Depends on rgb_def_pkg.
module rgb_def_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  rgb_def_pkg::job_t         push_data_i,
  input  logic                      pop_i,
  output rgb_def_pkg::job_t         head_o,
  output rgb_def_pkg::queue_stat_t  stat_o
);
  import rgb_def_pkg::*;

  job_t                 slots_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == QueueCntW'(QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = slots_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 3'd1;
    if (pop_i && !push_i) count_d = count_q - 3'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 2'd1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 2'd1;
      count_q <= count_d;
    end
  end

endmodule

/* rtl/core/rgb_def_back.sv */
// Back part of the edge filter: diagonal kernel, channel maximum and
// result sequencing into the output register. Depends on rgb_def_pkg.
module rgb_def_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rgb_def_pkg::job_t         head_i,
  input  rgb_def_pkg::queue_stat_t  queue_stat_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rgb_def_pkg::pix_out_t     out_data_o
);
  import rgb_def_pkg::*;

  logic           out_valid_q;
  pix_out_t       out_data_q, out_data_d;
  logic           border_next_q, border_next_d;
  logic           load;
  logic [ChW-1:0] ch_sum [3];
  logic [ChW-1:0] best;

  // Per channel: bottom-right - bottom-left - top-right + top-left, kept
  // only when it lands in 0..255.
  always_comb begin
    logic signed [9:0] s;
    for (int k = 0; k < 3; k++) begin
      s = $signed({2'b00, head_i.px[k*ChW +: ChW]})
        - $signed({2'b00, head_i.bot_left[k*ChW +: ChW]})
        - $signed({2'b00, head_i.top_right[k*ChW +: ChW]})
        + $signed({2'b00, head_i.top_left[k*ChW +: ChW]});
      ch_sum[k] = (s[9:8] == 2'b00) ? s[ChW-1:0] : '0;
    end
    best = ch_sum[0];
    if (ch_sum[1] > best) best = ch_sum[1];
    if (ch_sum[2] > best) best = ch_sum[2];
  end

  assign load = !queue_stat_i.empty && (!out_valid_q || out_ready_i);

  always_comb begin
    out_data_d    = out_data_q;
    border_next_d = border_next_q;
    pop_o         = 1'b0;
    if (load) begin
      if (head_i.has_inner && !border_next_q) begin
        out_data_d.out_row       = head_i.row - 12'd1;
        out_data_d.out_col       = head_i.col - 12'd1;
        out_data_d.out_red       = best;
        out_data_d.out_green     = best;
        out_data_d.out_blue      = best;
        out_data_d.is_edge_value = 1'b1;
        out_data_d.last_of_run   = !head_i.has_border;
        border_next_d            = head_i.has_border;
        pop_o                    = !head_i.has_border;
      end else begin
        out_data_d.out_row       = head_i.row;
        out_data_d.out_col       = head_i.col;
        out_data_d.out_red       = head_i.px[2*ChW +: ChW];
        out_data_d.out_green     = head_i.px[ChW +: ChW];
        out_data_d.out_blue      = head_i.px[0 +: ChW];
        out_data_d.is_edge_value = 1'b0;
        out_data_d.last_of_run   = 1'b1;
        border_next_d            = 1'b0;
        pop_o                    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      border_next_q <= 1'b0;
    end else begin
      border_next_q <= border_next_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/core/rgb_3x3_diagonal_edge_filter_top.sv */
// Streaming 3x3 diagonal edge filter on RGB pixels in raster order.
// Pixels enter on the in_* valid/ready channel, one item per pixel, with
// start_of_frame marking the first pixel of a frame. Results leave on the
// out_* valid/ready channel, each with its row and column. A border pixel
// gives a pass-through result; the pixel at (r,c) with r>=2 and c>=2 also
// completes the interior result for (r-1,c-1), which is sent first. So an
// item gives zero, one or two results, last_of_run set on the final one.
// A pixel is accepted every cycle while the queue has room; its results
// pass the stage 1 register and the queue into the output register. An
// item with two results sends them in turn, buffered by the short queue,
// which a long run of such items fills. If the receiver stalls, the
// output register holds, the queue fills, and in_ready_o drops. Image size
// is set over the APB port (image_width at 0x0, image_height at 0x4); the
// user must do so only while the block is idle, which it does not enforce.
// Reset: 640 x 480, position (0,0), zero window; line stores not cleared.
// Depends on rgb_def_pkg and the rgb_def_* modules.
module rgb_3x3_diagonal_edge_filter_top #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rgb_def_pkg::pix_in_t              in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rgb_def_pkg::pix_out_t             out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rgb_def_pkg::CfgAddrW-1:0]  paddr,
  input  logic [rgb_def_pkg::CfgDataW-1:0]  pwdata,
  output logic [rgb_def_pkg::CfgDataW-1:0]  prdata,
  output logic                              pready
);
  import rgb_def_pkg::*;

  logic [DimW-1:0] image_width, image_height;
  queue_stat_t     queue_stat;
  logic            push, pop;
  job_t            push_job, head_job;

  rgb_def_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .image_width_o  (image_width),
    .image_height_o (image_height)
  );

  rgb_def_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .image_width_i  (image_width),
    .image_height_i (image_height),
    .queue_stat_i   (queue_stat),
    .push_o         (push),
    .job_o          (push_job)
  );

  rgb_def_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .stat_o      (queue_stat)
  );

  rgb_def_back u_back (
    .clk_i,
    .rst_ni,
    .head_i       (head_job),
    .queue_stat_i (queue_stat),
    .pop_o        (pop),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule

/* tb/rgb_edge_result_checker.sv */
// Result checker for the RGB 3x3 diagonal edge filter testbench.
// Watches the pixel, result and APB channels, predicts each result and compares it.
// Depends on rgb_def_pkg for the payload types and register indexes.
module rgb_edge_result_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  rgb_def_pkg::pix_in_t              in_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  rgb_def_pkg::pix_out_t             out_data_i,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [rgb_def_pkg::CfgAddrW-1:0]  paddr_i,
  input  logic [rgb_def_pkg::CfgDataW-1:0]  pwdata_i,
  input  logic                              pready_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rgb_def_pkg::*;

  typedef struct packed {
    logic [PxW-1:0] top;
    logic [PxW-1:0] bot;
  } win_col_t;

  logic [DimW-1:0] width_cfg;
  logic [DimW-1:0] height_cfg;
  logic [PxW-1:0]  upper_line [CountLimit];
  logic [PxW-1:0]  middle_line [CountLimit];
  win_col_t        win_cols [2];
  int              row_pos;
  int              col_pos;
  int              mismatches;
  pix_out_t        due_results_q [$];

  function automatic int clamp_dim(input logic [DimW-1:0] v);
    if (v < MinDim) return int'(MinDim);
    if (v > CountCap) return int'(CountCap);
    return int'(v);
  endfunction

  task automatic clear_state();
    for (int i = 0; i < CountLimit; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    win_cols[0] = '0;
    win_cols[1] = '0;
    row_pos     = 0;
    col_pos     = 0;
    width_cfg   = WidthReset;
    height_cfg  = HeightReset;
    mismatches  = 0;
    due_results_q.delete();
  endtask

  // Works out the results one accepted pixel causes and queues them in order.
  task automatic filter_pixel(input pix_in_t pin);
    int             w, h, r, c, n, s, sh;
    logic [PxW-1:0] px;
    win_col_t       cur;
    logic [ChW-1:0] best;
    pix_out_t       res [2];
    w  = clamp_dim(width_cfg);
    h  = clamp_dim(height_cfg);
    px = {pin.in_red, pin.in_green, pin.in_blue};
    n  = 0;
    if (pin.start_of_frame) begin
      row_pos = 0;
      col_pos = 0;
    end
    // A position left past a shrunken size wraps before use.
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    cur.top = upper_line[c];
    cur.bot = px;

    if (r >= 2 && c >= 2) begin
      best = '0;
      for (int k = 0; k < 3; k++) begin
        sh = 16 - 8 * k;
        s = int'(cur.bot[sh +: ChW]) - int'(win_cols[1].bot[sh +: ChW])
          - int'(cur.top[sh +: ChW]) + int'(win_cols[1].top[sh +: ChW]);
        // Sums outside 0..255 count as no edge at all.
        if (s >= 0 && s <= 255 && s > int'(best)) best = ChW'(s);
      end
      res[n] = '0;
      res[n].out_row       = PosW'(r - 1);
      res[n].out_col       = PosW'(c - 1);
      res[n].out_red       = best;
      res[n].out_green     = best;
      res[n].out_blue      = best;
      res[n].is_edge_value = 1'b1;
      n++;
    end
    if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
      res[n] = '0;
      res[n].out_row   = PosW'(r);
      res[n].out_col   = PosW'(c);
      res[n].out_red   = pin.in_red;
      res[n].out_green = pin.in_green;
      res[n].out_blue  = pin.in_blue;
      n++;
    end
    if (n > 0) res[n - 1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) due_results_q.push_back(res[k]);

    upper_line[c]  = middle_line[c];
    middle_line[c] = px;
    win_cols[1]    = win_cols[0];
    win_cols[0]    = cur;

    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pix_out_t want;
    if (!rst_ni) begin
      clear_state();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == RegImageWidth) width_cfg = pwdata_i[DimW-1:0];
        else height_cfg = pwdata_i[DimW-1:0];
      end
      if (in_valid_i && in_ready_i) filter_pixel(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (due_results_q.size() == 0) begin
          $error("unexpected result at row %0d col %0d", out_data_i.out_row,
                 out_data_i.out_col);
          mismatches++;
        end else begin
          want = due_results_q.pop_front();
          compare_field("out_row", int'(want.out_row), int'(out_data_i.out_row));
          compare_field("out_col", int'(want.out_col), int'(out_data_i.out_col));
          compare_field("out_red", int'(want.out_red), int'(out_data_i.out_red));
          compare_field("out_green", int'(want.out_green), int'(out_data_i.out_green));
          compare_field("out_blue", int'(want.out_blue), int'(out_data_i.out_blue));
          compare_field("is_edge_value", int'(want.is_edge_value),
                        int'(out_data_i.is_edge_value));
          compare_field("last_of_run", int'(want.last_of_run),
                        int'(out_data_i.last_of_run));
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= due_results_q.size();
    end
  end

endmodule

/* tb/tb_rgb_3x3_diagonal_edge_filter_top.sv */
// Testbench top for the RGB 3x3 diagonal edge filter.
// Drives pixel frames and image sizes, stalls the receiver, and gives the verdict.
// Depends on rgb_def_pkg, the filter RTL and rgb_edge_result_checker.
module tb_rgb_3x3_diagonal_edge_filter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rgb_def_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 12;

  typedef enum int {RxFlowing, RxRandom, RxSluggish} rx_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  pix_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  pix_out_t            out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAddrW-1:0] paddr       = '0;
  logic [CfgDataW-1:0] pwdata      = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  int       fail_count;
  int       pending_results;
  int       burst_left = 0;
  int       idle_cycles = 0;
  rx_mode_e rx_mode = RxFlowing;
  int       rx_mode_left = 0;

  rgb_3x3_diagonal_edge_filter_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  rgb_edge_result_checker u_result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The receiver switches between free flow, coin-flip stalls and long stalls.
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(32, 256);
    end
    rx_mode_left--;
    case (rx_mode)
      RxFlowing: out_ready_i <= 1'b1;
      RxRandom:  out_ready_i <= 1'($urandom_range(0, 1));
      default:   out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [ChW-1:0] rand_chan();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return ChW'($urandom_range(0, 255));
    endcase
  endfunction

  // Writes both size registers back to back; bits above the register are random.
  task automatic set_image_size(input logic [DimW-1:0] width, input logic [DimW-1:0] height);
    logic            reg_idx;
    logic [DimW-1:0] value;
    for (int i = 0; i < 2; i++) begin
      reg_idx = (i == 0) ? RegImageWidth : RegImageHeight;
      value   = (i == 0) ? width : height;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= ($urandom() & 32'hFFFF_E000) | CfgDataW'(value);
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_pixel(input pix_in_t px);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    do @(posedge clk_i); while (pending_results != 0);
    // Items without a result may still sit in the pipeline.
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // A phase restarts the frame when the width grows, so that no line store
  // entry is read before this frame has written it.
  task automatic run_phase(input logic [DimW-1:0] width, input logic [DimW-1:0] height,
                           input int count, input bit restart);
    pix_in_t px;
    set_image_size(width, height);
    for (int k = 0; k < count; k++) begin
      px.start_of_frame = (k == 0 && restart) || ($urandom_range(0, 39) == 0);
      px.in_red         = rand_chan();
      px.in_green       = rand_chan();
      px.in_blue        = rand_chan();
      send_pixel(px);
    end
    in_valid_i <= 1'b0;
    burst_left = 0;
    drain_results();
  endtask

  initial begin
    pix_in_t px;
    int      r, c;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One 4x4 frame whose kernel sums land in range on red, overflow on green
    // along the diagonal and go negative on blue; then a wrap into the next
    // frame and a restart in the middle of it.
    set_image_size(13'd4, 13'd4);
    for (int i = 0; i < 22; i++) begin
      r = i / 4;
      c = i % 4;
      if (i < 16) begin
        px.start_of_frame = (i == 0);
        px.in_red         = ChW'(r * c * 28);
        px.in_green       = (r == c) ? 8'hFF : 8'h00;
        px.in_blue        = ChW'(255 - r * c * 28);
      end else begin
        px.start_of_frame = (i == 19);
        px.in_red         = rand_chan();
        px.in_green       = rand_chan();
        px.in_blue        = rand_chan();
      end
      send_pixel(px);
    end
    in_valid_i <= 1'b0;
    burst_left = 0;
    drain_results();

    run_phase(13'd12, 13'd7, 350, 1'b1);
    run_phase(13'd5, 13'd4, 250, 1'b0);
    run_phase(13'd3, 13'd3, 150, 1'b0);
    run_phase(13'd0, 13'd1, 100, 1'b0);
    run_phase(13'd9, 13'd6, 300, 1'b1);
    run_phase(13'd7, 13'h1FFF, 300, 1'b0);
    run_phase(13'h1FFF, 13'd5, 200, 1'b1);
    run_phase(13'd4096, 13'd4096, 50, 1'b0);
    run_phase(13'd2, 13'd2, 150, 1'b0);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
